/* rtl/tepq_pkg.sv */
// shared types, constants and codes of the timed event priority queue
package tepq_pkg;

    localparam int NUM_EVENT_TYPES = 16;
    localparam int ID_W = 4;
    localparam int CNT_W = $clog2(NUM_EVENT_TYPES + 1);
    localparam int TIME_W = 64;
    localparam int DELAY_W = 32;
    localparam int MODE_W = 2;
    localparam int COND_W = 2;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP = 2'd2;

    localparam logic [COND_W-1:0] COND_NONE = 2'd0;
    localparam logic [COND_W-1:0] COND_VBLANK = 2'd3;

    localparam logic REG_HBLANK = 1'b0;
    localparam logic REG_VBLANK = 1'b1;

    localparam logic [ID_W-1:0] HBLANK_RESET = 4'd0;
    localparam logic [ID_W-1:0] VBLANK_RESET = 4'd1;

    typedef struct packed {
        logic load;
        logic unlink;
        logic place;
    } cmd_t;

    typedef struct packed {
        logic out_valid;
        logic out_ready;
    } status_t;

endpackage

/* rtl/tepq_if.sv */
// handshake channels for transactions in and results out
interface tepq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [tepq_pkg::MODE_W-1:0]          mode;
    logic [tepq_pkg::ID_W-1:0]            event_id;
    logic [tepq_pkg::DELAY_W-1:0]         delay_cycles;
    logic [tepq_pkg::COND_W-1:0]          wait_condition;
    logic                                 ignore_wait;
    logic [tepq_pkg::TIME_W-1:0]          now_cycle;

    modport source (output valid, mode, event_id, delay_cycles, wait_condition,
                    ignore_wait, now_cycle, input ready);
    modport sink (input valid, mode, event_id, delay_cycles, wait_condition,
                  ignore_wait, now_cycle, output ready);
endinterface

interface tepq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 popped_valid;
    logic [tepq_pkg::ID_W-1:0]            popped_id;
    logic [tepq_pkg::TIME_W-1:0]          popped_cycle;
    logic                                 head_valid;
    logic [tepq_pkg::ID_W-1:0]            head_id;
    logic [tepq_pkg::TIME_W-1:0]          head_cycle;

    modport source (output valid, popped_valid, popped_id, popped_cycle, head_valid,
                    head_id, head_cycle, input ready);
    modport sink (input valid, popped_valid, popped_id, popped_cycle, head_valid,
                  head_id, head_cycle, output ready);
endinterface

/* rtl/timed_event_priority_queue_unit.sv */
// top level of the timed event priority queue: register port, controller, datapath
// a transaction is loaded in idle, unlinked in the unlink state and placed in the
// place state, which writes the result register; it waits while the result register
// holds an untaken result, and a new transaction is accepted only in idle
// reset: asynchronous active low, queue empty, hblank id 0, vblank id 1
module timed_event_priority_queue_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    tepq_in_if.sink                       in_ch,
    tepq_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tepq_pkg::ADDR_W-1:0]   paddr,
    input  logic [tepq_pkg::DATA_W-1:0]   pwdata,
    output logic [tepq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [tepq_pkg::ID_W-1:0] hblank_id_reg;
    logic [tepq_pkg::ID_W-1:0] vblank_id_reg;
    logic                      cfg_write;
    tepq_pkg::cmd_t            cmd;
    tepq_pkg::status_t         status;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hblank_id_reg <= tepq_pkg::HBLANK_RESET;
            vblank_id_reg <= tepq_pkg::VBLANK_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == tepq_pkg::REG_HBLANK)
            begin
                hblank_id_reg <= pwdata[tepq_pkg::ID_W-1:0];
            end
            else
            begin
                vblank_id_reg <= pwdata[tepq_pkg::ID_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == tepq_pkg::REG_HBLANK)
        begin
            prdata[tepq_pkg::ID_W-1:0] = hblank_id_reg;
        end
        else
        begin
            prdata[tepq_pkg::ID_W-1:0] = vblank_id_reg;
        end
    end

    tepq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    tepq_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .hblank_id (hblank_id_reg),
        .vblank_id (vblank_id_reg),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.popped_valid) |->
        (out_ch.popped_id == '0 && out_ch.popped_cycle == '0))
        else $error("popped fields not cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.head_valid) |->
        (out_ch.head_id == '0 && out_ch.head_cycle == '0))
        else $error("head fields not cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("accepted a transaction while busy");

endmodule

/* rtl/tepq_ctrl.sv */
// sequencing state machine of the queue
module tepq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tepq_pkg::status_t status,
    output tepq_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_UNLINK = 3'b010,
        ST_PLACE  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_UNLINK;
                end
            end
            ST_UNLINK:
            begin
                cmd.unlink = 1'b1;
                state_next = ST_PLACE;
            end
            ST_PLACE:
            begin
                if (!status.out_valid || status.out_ready)
                begin
                    cmd.place = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/tepq_dp.sv */
// ordered slot array, unlink and insert logic, result register
module tepq_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tepq_pkg::cmd_t                cmd,
    output tepq_pkg::status_t             status,
    input  logic [tepq_pkg::ID_W-1:0]     hblank_id,
    input  logic [tepq_pkg::ID_W-1:0]     vblank_id,
    tepq_in_if.sink                       in_ch,
    tepq_out_if.source                    out_ch
);

    localparam int N = tepq_pkg::NUM_EVENT_TYPES;

    logic [tepq_pkg::MODE_W-1:0]  mode_reg;
    logic [tepq_pkg::ID_W-1:0]    id_reg;
    logic [tepq_pkg::DELAY_W-1:0] delay_reg;
    logic [tepq_pkg::COND_W-1:0]  cond_reg;
    logic                         ign_reg;
    logic [tepq_pkg::TIME_W-1:0]  now_reg;

    logic [tepq_pkg::ID_W-1:0]    slot_id_reg [N];
    logic [tepq_pkg::TIME_W-1:0]  slot_due_reg [N];
    logic [tepq_pkg::COND_W-1:0]  slot_cond_reg [N];
    logic [tepq_pkg::CNT_W-1:0]   count_reg;

    logic [tepq_pkg::ID_W-1:0]    slot_id_next [N];
    logic [tepq_pkg::TIME_W-1:0]  slot_due_next [N];
    logic [tepq_pkg::COND_W-1:0]  slot_cond_next [N];
    logic [tepq_pkg::CNT_W-1:0]   count_next;

    logic                         out_valid_reg;
    logic                         popped_valid_reg;
    logic [tepq_pkg::ID_W-1:0]    popped_id_reg;
    logic [tepq_pkg::TIME_W-1:0]  popped_cycle_reg;
    logic                         head_valid_reg;
    logic [tepq_pkg::ID_W-1:0]    head_id_reg;
    logic [tepq_pkg::TIME_W-1:0]  head_cycle_reg;

    logic [N-1:0]                 slot_valid;
    logic [N-1:0]                 hit;
    logic [N-1:0]                 after_hit;
    logic [N-1:0]                 anchor_hit;
    logic [N-1:0]                 anchor_before;
    logic [N-1:0]                 cand;
    logic [N-1:0]                 from_pos;
    logic [tepq_pkg::TIME_W-1:0]  due_new;
    logic [tepq_pkg::TIME_W-1:0]  due_anchor;
    logic [tepq_pkg::TIME_W-1:0]  due_ins;
    logic [tepq_pkg::ID_W-1:0]    anchor_id;
    logic                         timed;
    logic                         is_add;
    logic                         pop_now;

    assign due_new = now_reg + {{(tepq_pkg::TIME_W-tepq_pkg::DELAY_W){1'b0}}, delay_reg};
    assign timed = (cond_reg == tepq_pkg::COND_NONE) || ign_reg;
    assign anchor_id = (cond_reg == tepq_pkg::COND_VBLANK) ? vblank_id : hblank_id;
    assign is_add = (mode_reg == tepq_pkg::MODE_ADD);
    assign pop_now = (mode_reg == tepq_pkg::MODE_POP) && (count_reg != '0)
                     && (slot_due_reg[0] <= now_reg);

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            slot_valid[i] = (tepq_pkg::CNT_W'(i) < count_reg);
            hit[i] = slot_valid[i] && (slot_id_reg[i] == id_reg);
            anchor_hit[i] = slot_valid[i] && (slot_id_reg[i] == anchor_id);
        end
        after_hit[0] = hit[0];
        anchor_before[0] = 1'b0;
        for (int i = 1; i < N; i++)
        begin
            after_hit[i] = after_hit[i-1] | hit[i];
            anchor_before[i] = anchor_before[i-1] | anchor_hit[i-1];
        end
        due_anchor = '0;
        for (int i = 0; i < N; i++)
        begin
            if (anchor_hit[i])
            begin
                due_anchor = due_anchor | slot_due_reg[i];
            end
        end
        due_ins = (!timed && (|anchor_hit)) ? due_anchor : due_new;
        for (int i = 0; i < N; i++)
        begin
            if (timed)
            begin
                cand[i] = !slot_valid[i] || (slot_due_reg[i] > due_new)
                          || ((slot_due_reg[i] == due_new) && (id_reg < slot_id_reg[i]));
            end
            else
            begin
                cand[i] = !slot_valid[i] || (anchor_before[i]
                          && !((slot_id_reg[i] < id_reg) && (slot_cond_reg[i] == cond_reg)));
            end
        end
        from_pos[0] = cand[0];
        for (int i = 1; i < N; i++)
        begin
            from_pos[i] = from_pos[i-1] | cand[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            slot_id_next[i] = slot_id_reg[i];
            slot_due_next[i] = slot_due_reg[i];
            slot_cond_next[i] = slot_cond_reg[i];
        end
        count_next = count_reg;
        if (cmd.unlink && (mode_reg == tepq_pkg::MODE_ADD
                           || mode_reg == tepq_pkg::MODE_REMOVE) && (|hit))
        begin
            for (int i = 0; i < N - 1; i++)
            begin
                if (after_hit[i])
                begin
                    slot_id_next[i] = slot_id_reg[i+1];
                    slot_due_next[i] = slot_due_reg[i+1];
                    slot_cond_next[i] = slot_cond_reg[i+1];
                end
            end
            count_next = count_reg - 1'b1;
        end
        else if (cmd.place && is_add)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (from_pos[i])
                begin
                    if (i > 0 && from_pos[(i > 0) ? i - 1 : 0])
                    begin
                        slot_id_next[i] = slot_id_reg[(i > 0) ? i - 1 : 0];
                        slot_due_next[i] = slot_due_reg[(i > 0) ? i - 1 : 0];
                        slot_cond_next[i] = slot_cond_reg[(i > 0) ? i - 1 : 0];
                    end
                    else
                    begin
                        slot_id_next[i] = id_reg;
                        slot_due_next[i] = due_ins;
                        slot_cond_next[i] = cond_reg;
                    end
                end
            end
            count_next = count_reg + 1'b1;
        end
        else if (cmd.place && pop_now)
        begin
            for (int i = 0; i < N - 1; i++)
            begin
                slot_id_next[i] = slot_id_reg[i+1];
                slot_due_next[i] = slot_due_reg[i+1];
                slot_cond_next[i] = slot_cond_reg[i+1];
            end
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            slot_id_reg[i] <= slot_id_next[i];
            slot_due_reg[i] <= slot_due_next[i];
            slot_cond_reg[i] <= slot_cond_next[i];
        end
        if (cmd.load)
        begin
            mode_reg <= in_ch.mode;
            id_reg <= in_ch.event_id;
            delay_reg <= in_ch.delay_cycles;
            cond_reg <= in_ch.wait_condition;
            ign_reg <= in_ch.ignore_wait;
            now_reg <= in_ch.now_cycle;
        end
        if (cmd.place)
        begin
            popped_valid_reg <= pop_now;
            popped_id_reg <= pop_now ? slot_id_reg[0] : '0;
            popped_cycle_reg <= pop_now ? slot_due_reg[0] : '0;
            head_valid_reg <= (count_next != '0);
            head_id_reg <= (count_next != '0) ? slot_id_next[0] : '0;
            head_cycle_reg <= (count_next != '0) ? slot_due_next[0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.place)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_valid = out_valid_reg;
    assign status.out_ready = out_ch.ready;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.popped_valid = popped_valid_reg;
    assign out_ch.popped_id = popped_id_reg;
    assign out_ch.popped_cycle = popped_cycle_reg;
    assign out_ch.head_valid = head_valid_reg;
    assign out_ch.head_id = head_id_reg;
    assign out_ch.head_cycle = head_cycle_reg;

endmodule

/* verif/tepq_checker.sv */
// checker for the timed event priority queue: tracks register writes, predicts and compares results
`timescale 1ns / 100ps

module tepq_checker
    import tepq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    tepq_in_if                  in_ch,
    tepq_out_if                 out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    input  logic                pready,
    output int                  errors,
    output int                  pending
);

    localparam int NIL = NUM_EVENT_TYPES;

    typedef struct {
        logic              popped_valid;
        logic [ID_W-1:0]   popped_id;
        logic [TIME_W-1:0] popped_cycle;
        logic              head_valid;
        logic [ID_W-1:0]   head_id;
        logic [TIME_W-1:0] head_cycle;
    } outcome_t;

    outcome_t          outcome_q[$];
    logic [TIME_W-1:0] due[NUM_EVENT_TYPES];
    logic [COND_W-1:0] cond_of[NUM_EVENT_TYPES];
    int                nxt[NUM_EVENT_TYPES];
    int                head;
    logic [ID_W-1:0]   hblank_id;
    logic [ID_W-1:0]   vblank_id;

    function automatic void unlink_event(int id);
        int cur;
        int nx;
        if (head == NIL)
        begin
            nxt[id] = NIL;
            return;
        end
        if (head == id)
        begin
            head = nxt[id];
            nxt[id] = NIL;
            return;
        end
        cur = head;
        for (int s = 0; s < NIL && cur < NIL; s++)
        begin
            nx = nxt[cur];
            if (nx == NIL)
                break;
            if (nx == id)
            begin
                nxt[cur] = nxt[id];
                break;
            end
            cur = nx;
        end
        nxt[id] = NIL;
    endfunction

    function automatic void insert_event(int id, logic [DELAY_W-1:0] delay,
                                         logic [COND_W-1:0] cond, logic ign,
                                         logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] when;
        int                prev;
        int                cur;
        int                anchor;
        bit                found;
        when = now + TIME_W'(delay);
        prev = NIL;
        found = 0;
        unlink_event(id);
        cond_of[id] = cond;
        cur = head;
        if (cond == COND_NONE || ign)
        begin
            for (int s = 0; s < NIL && cur < NIL; s++)
            begin
                if (due[cur] > when || (due[cur] == when && id < cur))
                    break;
                prev = cur;
                cur = nxt[cur];
            end
        end
        else
        begin
            anchor = (cond == COND_VBLANK) ? int'(vblank_id) : int'(hblank_id);
            for (int s = 0; s < NIL && cur < NIL; s++)
            begin
                if (cur == anchor)
                begin
                    found = 1;
                    break;
                end
                prev = cur;
                cur = nxt[cur];
            end
            if (found)
            begin
                when = due[cur];
                prev = cur;
                cur = nxt[cur];
                for (int s = 0; s < NIL && cur < NIL; s++)
                begin
                    if (!(cur < id && cond_of[cur] == cond))
                        break;
                    prev = cur;
                    cur = nxt[cur];
                end
            end
        end
        due[id] = when;
        nxt[id] = cur;
        if (prev < NIL)
            nxt[prev] = id;
        else
            head = id;
    endfunction

    function automatic outcome_t predict_outcome();
        outcome_t o;
        int       h;
        o = '{default: '0};
        if (in_ch.mode == MODE_ADD)
            insert_event(int'(in_ch.event_id), in_ch.delay_cycles, in_ch.wait_condition,
                         in_ch.ignore_wait, in_ch.now_cycle);
        else if (in_ch.mode == MODE_REMOVE)
            unlink_event(int'(in_ch.event_id));
        else if (in_ch.mode == MODE_POP && head < NIL && due[head] <= in_ch.now_cycle)
        begin
            h = head;
            o.popped_valid = 1'b1;
            o.popped_id = ID_W'(h);
            o.popped_cycle = due[h];
            head = nxt[h];
            nxt[h] = NIL;
        end
        if (head < NIL)
        begin
            o.head_valid = 1'b1;
            o.head_id = ID_W'(head);
            o.head_cycle = due[head];
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_EVENT_TYPES; i++)
            begin
                due[i] = '0;
                cond_of[i] = COND_NONE;
                nxt[i] = NIL;
            end
            head = NIL;
            hblank_id = HBLANK_RESET;
            vblank_id = VBLANK_RESET;
            outcome_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_VBLANK)
                    vblank_id = pwdata[ID_W-1:0];
                else
                    hblank_id = pwdata[ID_W-1:0];
            end
            if (in_ch.valid && in_ch.ready)
                outcome_q.push_back(predict_outcome());
            if (out_ch.valid && out_ch.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result with no transaction pending");
                    errors++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (out_ch.popped_valid !== want.popped_valid)
                    begin
                        $error("popped_valid expected %0d actual %0d",
                               want.popped_valid, out_ch.popped_valid);
                        errors++;
                    end
                    if (out_ch.popped_id !== want.popped_id)
                    begin
                        $error("popped_id expected %0d actual %0d",
                               want.popped_id, out_ch.popped_id);
                        errors++;
                    end
                    if (out_ch.popped_cycle !== want.popped_cycle)
                    begin
                        $error("popped_cycle expected %0h actual %0h",
                               want.popped_cycle, out_ch.popped_cycle);
                        errors++;
                    end
                    if (out_ch.head_valid !== want.head_valid)
                    begin
                        $error("head_valid expected %0d actual %0d",
                               want.head_valid, out_ch.head_valid);
                        errors++;
                    end
                    if (out_ch.head_id !== want.head_id)
                    begin
                        $error("head_id expected %0d actual %0d",
                               want.head_id, out_ch.head_id);
                        errors++;
                    end
                    if (out_ch.head_cycle !== want.head_cycle)
                    begin
                        $error("head_cycle expected %0h actual %0h",
                               want.head_cycle, out_ch.head_cycle);
                        errors++;
                    end
                end
            end
            pending = outcome_q.size();
        end
    end

endmodule

/* verif/timed_event_priority_queue_unit_test.sv */
// testbench top for the timed event priority queue: stimulus, register writes and verdict
`timescale 1ns / 100ps

module timed_event_priority_queue_unit_test;
    import tepq_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam logic [1:0] MODE_IDLE = 2'd3;
    localparam logic [COND_W-1:0] COND_HBLANK = 2'd1;
    localparam logic [COND_W-1:0] COND_DMA3 = 2'd2;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                errors;
    int                pending;
    int                quiet_cycles;
    bit                calm_in;
    bit                calm_out;
    logic [TIME_W-1:0] now_base;

    tepq_in_if  in_ch ();
    tepq_out_if out_ch ();

    timed_event_priority_queue_unit u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tepq_checker u_checker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timed_event_priority_queue_unit_test: errors");
            $finish;
        end
    end

    // result side: random stall before each result, none while calm_out is set
    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = calm_out ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    task automatic send(logic [1:0] mode, logic [ID_W-1:0] id, logic [DELAY_W-1:0] delay,
                        logic [COND_W-1:0] cond, logic ign, logic [TIME_W-1:0] now);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.event_id <= id;
        in_ch.delay_cycles <= delay;
        in_ch.wait_condition <= cond;
        in_ch.ignore_wait <= ign;
        in_ch.now_cycle <= now;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [ID_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {28'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_random(int count, int calm_span);
        int                r;
        logic [1:0]        mode;
        logic [DELAY_W-1:0] delay;
        for (int n = 0; n < count; n++)
        begin
            calm_in = (n < calm_span);
            calm_out = (n < calm_span / 2) || (n >= count - calm_span / 2);
            r = $urandom_range(0, 99);
            if (r < 45)
                mode = MODE_ADD;
            else if (r < 60)
                mode = MODE_REMOVE;
            else if (r < 96)
                mode = MODE_POP;
            else
                mode = MODE_IDLE;
            delay = ($urandom_range(0, 4) == 0) ? DELAY_W'($urandom)
                                                : DELAY_W'($urandom_range(0, 60));
            now_base = now_base + TIME_W'($urandom_range(0, 20));
            send(mode, ID_W'($urandom_range(0, 15)), delay, COND_W'($urandom_range(0, 3)),
                 ($urandom_range(0, 4) == 0), now_base);
        end
        calm_in = 0;
        calm_out = 0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        quiet_cycles <= 0;
        calm_in = 0;
        calm_out = 0;
        in_ch.valid <= 1'b0;
        in_ch.mode <= MODE_ADD;
        in_ch.event_id <= '0;
        in_ch.delay_cycles <= '0;
        in_ch.wait_condition <= COND_NONE;
        in_ch.ignore_wait <= 1'b0;
        in_ch.now_cycle <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(REG_HBLANK, 4'd0);
        write_reg(REG_VBLANK, 4'd1);
        // empty queue corner cases
        send(MODE_POP, 4'd0, '0, COND_NONE, 1'b0, '0);
        send(MODE_REMOVE, 4'd5, '0, COND_NONE, 1'b0, '0);
        send(MODE_IDLE, 4'd9, '1, COND_VBLANK, 1'b1, '1);
        // anchor missing goes to tail, anchor equal to added type
        send(MODE_ADD, 4'd9, 32'd100, COND_HBLANK, 1'b0, 64'd10);
        send(MODE_ADD, 4'd0, 32'd50, COND_HBLANK, 1'b0, 64'd10);
        send(MODE_ADD, 4'd0, 32'd40, COND_NONE, 1'b0, 64'd10);
        send(MODE_ADD, 4'd15, 32'd40, COND_NONE, 1'b0, 64'd10);
        send(MODE_ADD, 4'd1, 32'd80, COND_NONE, 1'b0, 64'd10);
        send(MODE_ADD, 4'd6, '0, COND_DMA3, 1'b0, 64'd10);
        send(MODE_ADD, 4'd3, '0, COND_DMA3, 1'b0, 64'd10);
        send(MODE_ADD, 4'd2, '0, COND_HBLANK, 1'b0, 64'd10);
        send(MODE_ADD, 4'd12, 32'd5, COND_VBLANK, 1'b0, 64'd10);
        send(MODE_ADD, 4'd13, 32'd5, COND_VBLANK, 1'b1, 64'd10);
        send(MODE_REMOVE, 4'd15, '0, COND_NONE, 1'b0, '0);
        send(MODE_REMOVE, 4'd15, '0, COND_NONE, 1'b0, '0);
        send(MODE_POP, 4'd0, '0, COND_NONE, 1'b0, 64'd5);
        send(MODE_POP, 4'd0, '0, COND_NONE, 1'b0, 64'd15);
        // time wrap at the top of the range
        send(MODE_ADD, 4'd7, '1, COND_NONE, 1'b0, '1);
        send(MODE_ADD, 4'd8, '1, COND_NONE, 1'b1, 64'hFFFF_FFFF_0000_0000);
        for (int i = 0; i < 6; i++)
            send(MODE_POP, 4'd0, '0, COND_NONE, 1'b0, '1);
        now_base = 64'd1000;
        run_random(100, 0);
        drain();

        write_reg(REG_HBLANK, 4'd15);
        write_reg(REG_VBLANK, 4'd0);
        now_base = {$urandom, $urandom};
        run_random(100, 30);
        drain();

        write_reg(REG_HBLANK, 4'd7);
        write_reg(REG_VBLANK, 4'd7);
        run_random(100, 0);
        drain();

        write_reg(REG_HBLANK, 4'd3);
        write_reg(REG_VBLANK, 4'd12);
        now_base = 64'hFFFF_FFFF_FFFF_FE00;
        run_random(100, 20);
        drain();

        if (errors == 0)
            $display("timed_event_priority_queue_unit_test: clean");
        else
            $display("timed_event_priority_queue_unit_test: errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/tepq_pkg.sv
rtl/tepq_if.sv
rtl/tepq_ctrl.sv
rtl/tepq_dp.sv
rtl/timed_event_priority_queue_unit.sv
verif/tepq_checker.sv
verif/timed_event_priority_queue_unit_test.sv
